>>> src/assert_macros.svh
// assertion macros for the rtl that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define QSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define QSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/qss_pkg.sv
// shared constants and types of the quad scanline span block
package qss_pkg;

  localparam int CW       = 19;
  localparam int ROW_W    = 9;
  localparam int COLOUR_W = 32;

  localparam int SCREEN_WIDTH_DEF  = 512;
  localparam int SCREEN_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF     = 4;

  // numerator of a crossing: sum of two products of terms of up to CW+1 bits
  localparam int NUMW = 2 * (CW + 1) + 1;

  typedef struct packed {
    logic signed [CW-1:0] xa;
    logic signed [CW:0]   d;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dyr;
  } lane_t;

  typedef struct packed {
    logic                ok;
    lane_t [1:0]         lanes;
    logic [COLOUR_W-1:0] colour;
  } front_t;

endpackage

>>> src/qss_front.sv
// front end: edge crossing tests, selection of the two crossing edges and the on screen row check
module qss_front import qss_pkg::*; #(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic signed [CW-1:0] vx [4],
  input  logic signed [CW-1:0] vy [4],
  input  logic [ROW_W-1:0]     scan_row,
  input  logic [COLOUR_W-1:0]  colour,
  output front_t               item
);

  function automatic logic [1:0] low_idx(input logic [3:0] v);
    logic [1:0] r;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      if (v[i]) r = 2'(i);
    end
    return r;
  endfunction

  logic signed [CW:0] yrow;
  logic [3:0]         cross_hit;
  lane_t              lane_all [4];
  logic [1:0]         first_idx;
  logic [1:0]         second_idx;

  assign yrow = $signed((CW+1)'(scan_row) << FRAC_BITS);

  for (genvar e = 0; e < 4; e++) begin : g_edge
    localparam int N = (e + 1) % 4;
    logic signed [CW:0] ya, yb, xa, xb;
    assign ya = {vy[e][CW-1], vy[e]};
    assign yb = {vy[N][CW-1], vy[N]};
    assign xa = {vx[e][CW-1], vx[e]};
    assign xb = {vx[N][CW-1], vx[N]};
    assign cross_hit[e] = (ya <= yrow && yb > yrow) || (yb <= yrow && ya > yrow);
    assign lane_all[e].xa  = vx[e];
    assign lane_all[e].d   = yb - ya;
    assign lane_all[e].dx  = xb - xa;
    assign lane_all[e].dyr = yrow - ya;
  end

  assign first_idx  = low_idx(cross_hit);
  assign second_idx = low_idx(cross_hit & ~(4'b0001 << first_idx));

  always_comb begin
    item.ok       = ($countones(cross_hit) == 2) && (32'(scan_row) < SCREEN_HEIGHT);
    item.lanes[0] = lane_all[first_idx];
    item.lanes[1] = lane_all[second_idx];
    item.colour   = colour;
  end

endmodule

>>> src/qss_queue.sv
// two entry queue between front end and back end
module qss_queue import qss_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  front_t wr_data,
  output logic   is_full,
  input  logic   rd_en,
  output logic   rd_valid,
  output front_t rd_data
);

  front_t     data_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign is_full  = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    cnt_nxt    = cnt_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) data_r[wr_ptr_r] <= wr_data;
  end

endmodule

>>> src/qss_back.sv
// back end: crossing products, pipelined restoring division, clamp and output register
module qss_back import qss_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int XW           = $clog2(SCREEN_WIDTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  front_t              q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic                span_valid,
  output logic [XW-1:0]       span_left,
  output logic [XW-1:0]       span_right,
  output logic [COLOUR_W-1:0] span_colour
);

  localparam int QB   = CW - FRAC_BITS;
  localparam int DENW = CW + FRAC_BITS;
  localparam int PW   = ((QB + 2) > (XW + 2)) ? (QB + 2) : (XW + 2);

  logic adv;

  // multiply stage
  logic                   m_v_r;
  logic                   m_ok_r;
  logic [COLOUR_W-1:0]    m_col_r;
  logic signed [NUMW-1:0] m_p1_r [2];
  logic signed [NUMW-1:0] m_p2_r [2];
  logic [DENW-1:0]        m_den_r [2];
  logic                   m_dneg_r [2];

  // divider stages, index 0 holds the magnitudes
  logic                v_r   [QB+1];
  logic                ok_r  [QB+1];
  logic [COLOUR_W-1:0] col_r [QB+1];
  logic [NUMW-1:0]     rem_r [QB+1][2];
  logic [NUMW-1:0]     rem_nxt [QB+1][2];
  logic [QB-1:0]       quo_r [QB+1][2];
  logic [QB-1:0]       quo_nxt [QB+1][2];
  logic [DENW-1:0]     den_r [QB+1][2];
  logic                neg_r [QB+1][2];

  logic                out_v_r;

  assign adv   = !out_v_r || pop;
  assign q_pop = adv && q_valid;
  assign empty = !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      for (int k = 0; k <= QB; k++) v_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= q_valid;
      v_r[0] <= m_v_r;
      for (int k = 1; k <= QB; k++) v_r[k] <= v_r[k-1];
      out_v_r <= v_r[QB];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [CW:0]     dabs;
    logic signed [NUMW-1:0] num;
    assign dabs = q_data.lanes[l].d[CW] ? -$signed(q_data.lanes[l].d)
                                        : $signed(q_data.lanes[l].d);
    assign num  = m_p1_r[l] + m_p2_r[l];

    always_ff @(posedge clk) begin
      if (adv) begin
        m_p1_r[l]   <= NUMW'($signed(q_data.lanes[l].xa) * $signed(q_data.lanes[l].d));
        m_p2_r[l]   <= NUMW'($signed(q_data.lanes[l].dyr) * $signed(q_data.lanes[l].dx));
        m_den_r[l]  <= DENW'(dabs[CW-1:0]) << FRAC_BITS;
        m_dneg_r[l] <= q_data.lanes[l].d[CW];
        rem_r[0][l] <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
        quo_r[0][l] <= '0;
        den_r[0][l] <= m_den_r[l];
        neg_r[0][l] <= num[NUMW-1] ^ m_dneg_r[l];
      end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QB; k++) begin : g_div
      localparam int S = QB - k;
      logic [NUMW:0] diff;
      assign diff = {1'b0, rem_r[k-1][l]} - {1'b0, NUMW'(den_r[k-1][l]) << S};
      always_comb begin
        if (!diff[NUMW]) begin
          rem_nxt[k][l] = diff[NUMW-1:0];
          quo_nxt[k][l] = quo_r[k-1][l] | (QB'(1) << S);
        end else begin
          rem_nxt[k][l] = rem_r[k-1][l];
          quo_nxt[k][l] = quo_r[k-1][l];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k][l] <= rem_nxt[k][l];
          quo_r[k][l] <= quo_nxt[k][l];
          den_r[k][l] <= den_r[k-1][l];
          neg_r[k][l] <= neg_r[k-1][l];
        end
      end
    end
  end

  // stage zero has no divide step
  always_comb begin
    rem_nxt[0][0] = rem_r[0][0];
    rem_nxt[0][1] = rem_r[0][1];
    quo_nxt[0][0] = quo_r[0][0];
    quo_nxt[0][1] = quo_r[0][1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ok_r   <= q_data.ok;
      m_col_r  <= q_data.colour;
      ok_r[0]  <= m_ok_r;
      col_r[0] <= m_col_r;
      for (int k = 1; k <= QB; k++) begin
        ok_r[k]  <= ok_r[k-1];
        col_r[k] <= col_r[k-1];
      end
    end
  end

  // signed crossings, ordering and clamp
  logic signed [QB:0]   qs [2];
  logic signed [PW-1:0] lo, hi, lw, lcl, rcl, rmax;
  logic                 valid_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qs[l] = neg_r[QB][l] ? -$signed({1'b0, quo_r[QB][l]}) : $signed({1'b0, quo_r[QB][l]});
    end
    lo   = (qs[0] < qs[1]) ? PW'(qs[0]) : PW'(qs[1]);
    hi   = (qs[0] < qs[1]) ? PW'(qs[1]) : PW'(qs[0]);
    rmax = $signed(PW'(SCREEN_WIDTH - 1));
    lw   = lo + PW'(1);
    lcl  = (lw < 0) ? '0 : lw;
    rcl  = (hi > rmax) ? rmax : hi;
    valid_nxt = ok_r[QB] && (lcl <= rcl);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      span_valid  <= valid_nxt;
      span_left   <= valid_nxt ? lcl[XW-1:0] : '0;
      span_right  <= valid_nxt ? rcl[XW-1:0] : '0;
      span_colour <= col_r[QB];
    end
  end

endmodule

>>> src/quad_scanline_span.sv
// throughput: one beat per cycle while the output register is free or popped; it is set
// by the fully pipelined divider, one quotient bit a stage
// the two entry queue after the front end and the output register let each side stall alone
// reset: synchronous active low rst_n empties the queue and pipeline, clears full, sets empty
// a span beat waits in the output register until popped; the back end stalls behind it
module quad_scanline_span import qss_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic signed [CW-1:0]              in_vert0_x,
  input  logic signed [CW-1:0]              in_vert0_y,
  input  logic signed [CW-1:0]              in_vert1_x,
  input  logic signed [CW-1:0]              in_vert1_y,
  input  logic signed [CW-1:0]              in_vert2_x,
  input  logic signed [CW-1:0]              in_vert2_y,
  input  logic signed [CW-1:0]              in_vert3_x,
  input  logic signed [CW-1:0]              in_vert3_y,
  input  logic [ROW_W-1:0]                  in_scan_row,
  input  logic [COLOUR_W-1:0]               in_fill_colour,
  output logic                              empty,
  input  logic                              pop,
  output logic                              out_span_valid,
  output logic [$clog2(SCREEN_WIDTH)-1:0]   out_span_left,
  output logic [$clog2(SCREEN_WIDTH)-1:0]   out_span_right,
  output logic [COLOUR_W-1:0]               out_span_colour
);

`include "assert_macros.svh"

  localparam int XW = $clog2(SCREEN_WIDTH);

  // vertices gathered for the edge tests
  logic signed [CW-1:0] vx [4];
  logic signed [CW-1:0] vy [4];

  front_t front_item;  // classified beat from the front end
  front_t q_head;      // oldest beat waiting for the back end
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   push_ok;

  // both span columns side by side, for the checks below
  logic [2*XW-1:0] out_cols;

  assign vx[0] = in_vert0_x;
  assign vx[1] = in_vert1_x;
  assign vx[2] = in_vert2_x;
  assign vx[3] = in_vert3_x;
  assign vy[0] = in_vert0_y;
  assign vy[1] = in_vert1_y;
  assign vy[2] = in_vert2_y;
  assign vy[3] = in_vert3_y;

  assign full    = q_full;
  assign push_ok = push && !q_full;

  assign out_cols = {out_span_left, out_span_right};

  // front end: crossing tests, first two crossing edges, on screen check
  qss_front #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .vx       (vx),
    .vy       (vy),
    .scan_row (in_scan_row),
    .colour   (in_fill_colour),
    .item     (front_item)
  );

  // decoupling queue, the classified beat is held here until the back end takes it
  qss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push_ok),
    .wr_data  (front_item),
    .is_full  (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_head)
  );

  // back end: products, division of both crossings, clamp, output register
  qss_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .XW           (XW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .span_valid  (out_span_valid),
    .span_left   (out_span_left),
    .span_right  (out_span_right),
    .span_colour (out_span_colour)
  );

  // a valid span is never reversed
  `QSS_ASSERT(a_span_order, !empty && out_span_valid |-> out_span_left <= out_span_right, "span reversed")
  // no span means zeroed columns
  `QSS_ASSERT(a_span_zero, !empty && !out_span_valid |-> out_cols == '0, "columns set without a span")
  // back end only drains a queue that holds a beat
  `QSS_ASSERT(a_pop_valid, q_pop |-> q_valid, "queue drained while empty")
  // reset leaves no result waiting
  `QSS_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> empty, "result waiting after reset")

endmodule
